/* hw/rtl/particle_age_color_ramp_macros.svh */
// Assertion macros for the particle age color ramp block.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef PARTICLE_AGE_COLOR_RAMP_MACROS_SVH
`define PARTICLE_AGE_COLOR_RAMP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define PACR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pacr assertion failed");
// Next-cycle implication, disabled during reset.
`define PACR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pacr assertion failed");
`else
`define PACR_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PACR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hw/rtl/pacr_pkg.sv */
// Shared types and constants for the particle age color ramp block.
// No dependencies; used by every module of the block.
package pacr_pkg;

  localparam int NUM_COLOR_STOPS_DEF = 4;
  localparam int NUM_STOP_REGS       = 4;
  localparam int POS_W               = 32;
  localparam int HA_W                = 16;
  localparam int CH_W                = 16;
  localparam int FRAC_W              = 16;
  localparam int STOP_W              = 3 * CH_W;
  localparam int APB_DATA_W          = 64;
  localparam int APB_ADDR_W          = 6;
  localparam int DIV_STEPS           = 4;

  localparam logic [HA_W-1:0] HIGH_AGE_RESET = 16'd384;
  localparam logic [STOP_W-1:0] STOP_RESET [NUM_STOP_REGS] = '{
    48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_0000,
    48'hFFFF_0000_0000, 48'h4CCD_0000_0000
  };

  // Register map, one 64-bit slot per register
  typedef enum logic [2:0] {
    REG_HIGH_AGE     = 3'd0,
    REG_COLOR_STOP_0 = 3'd1,
    REG_COLOR_STOP_1 = 3'd2,
    REG_COLOR_STOP_2 = 3'd3,
    REG_COLOR_STOP_3 = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } pos_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

endpackage

/* hw/rtl/pacr_cfg_regs.sv */
// APB register file: high age and the color stops.
// Depends on pacr_pkg for widths, reset values and the register map.
module pacr_cfg_regs #(
  parameter int NUM_COLOR_STOPS = pacr_pkg::NUM_COLOR_STOPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pacr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pacr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pacr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [pacr_pkg::HA_W-1:0]         high_age_o,
  output logic [pacr_pkg::STOP_W-1:0]       stops_o [NUM_COLOR_STOPS]
);

  pacr_pkg::reg_idx_e              idx;
  logic                            wr_en;
  logic                            ha_we;
  logic [pacr_pkg::NUM_STOP_REGS-1:0] stop_we;
  logic [pacr_pkg::HA_W-1:0]       high_age_q;
  logic [pacr_pkg::STOP_W-1:0]     stop_rd [pacr_pkg::NUM_STOP_REGS];

  assign pready = 1'b1;
  assign idx    = pacr_pkg::reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Decode the write strobe per register
  always_comb begin
    ha_we   = 1'b0;
    stop_we = '0;
    if (wr_en) begin
      unique case (idx)
        pacr_pkg::REG_HIGH_AGE:     ha_we      = 1'b1;
        pacr_pkg::REG_COLOR_STOP_0: stop_we[0] = 1'b1;
        pacr_pkg::REG_COLOR_STOP_1: stop_we[1] = 1'b1;
        pacr_pkg::REG_COLOR_STOP_2: stop_we[2] = 1'b1;
        pacr_pkg::REG_COLOR_STOP_3: stop_we[3] = 1'b1;
        default:                    ha_we      = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_age_q <= pacr_pkg::HIGH_AGE_RESET;
    end else if (ha_we) begin
      high_age_q <= pwdata[pacr_pkg::HA_W-1:0];
    end
  end

  assign high_age_o = high_age_q;

  // Stops backed by a register; extra stops read as zero
  for (genvar k = 0; k < NUM_COLOR_STOPS; k++) begin : g_stop
    if (k < pacr_pkg::NUM_STOP_REGS) begin : g_reg
      logic [pacr_pkg::STOP_W-1:0] stop_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          stop_q <= pacr_pkg::STOP_RESET[k];
        end else if (stop_we[k]) begin
          stop_q <= pwdata[pacr_pkg::STOP_W-1:0];
        end
      end
      assign stops_o[k] = stop_q;
    end else begin : g_zero
      assign stops_o[k] = '0;
    end
  end

  // Readback view of the register slots
  for (genvar k = 0; k < pacr_pkg::NUM_STOP_REGS; k++) begin : g_rd
    if (k < NUM_COLOR_STOPS) begin : g_live
      assign stop_rd[k] = stops_o[k];
    end else begin : g_none
      assign stop_rd[k] = '0;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      pacr_pkg::REG_HIGH_AGE:
        prdata = pacr_pkg::APB_DATA_W'(high_age_q);
      pacr_pkg::REG_COLOR_STOP_0: prdata = pacr_pkg::APB_DATA_W'(stop_rd[0]);
      pacr_pkg::REG_COLOR_STOP_1: prdata = pacr_pkg::APB_DATA_W'(stop_rd[1]);
      pacr_pkg::REG_COLOR_STOP_2: prdata = pacr_pkg::APB_DATA_W'(stop_rd[2]);
      pacr_pkg::REG_COLOR_STOP_3: prdata = pacr_pkg::APB_DATA_W'(stop_rd[3]);
      default:                    prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/pacr_div_stage.sv */
// One registered stage of the restoring divider for the scaled age.
// Depends on pacr_pkg; resolves STEPS quotient bits from bit BASE downward.
module pacr_div_stage #(
  parameter int NW    = 18,
  parameter int BASE  = 17,
  parameter int STEPS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pacr_pkg::HA_W-1:0]   ha_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [NW-1:0]               n_i,
  input  logic [pacr_pkg::HA_W-1:0]   rem_i,
  input  logic [NW-1:0]               quo_i,
  input  logic                        ovf_i,
  input  pacr_pkg::pos_t              pos_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [NW-1:0]               n_o,
  output logic [pacr_pkg::HA_W-1:0]   rem_o,
  output logic [NW-1:0]               quo_o,
  output logic                        ovf_o,
  output pacr_pkg::pos_t              pos_o
);

  logic [NW+pacr_pkg::FRAC_W-1:0] dvd;
  logic [pacr_pkg::HA_W:0]        r;
  logic [NW-1:0]                  q;
  logic                           valid_q;
  logic [NW-1:0]                  n_q;
  logic [pacr_pkg::HA_W-1:0]      rem_q;
  logic [NW-1:0]                  quo_q;
  logic                           ovf_q;
  pacr_pkg::pos_t                 pos_q;

  // Shift in one dividend bit per step, subtract the divisor when it fits
  always_comb begin
    dvd = {n_i, pacr_pkg::FRAC_W'(0)};
    r   = {1'b0, rem_i};
    q   = quo_i;
    for (int j = 0; j < STEPS; j++) begin
      r = {r[pacr_pkg::HA_W-1:0], dvd[BASE-j]};
      if (r >= {1'b0, ha_i}) begin
        r          = r - {1'b0, ha_i};
        q[BASE-j]  = 1'b1;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      n_q   <= n_i;
      rem_q <= r[pacr_pkg::HA_W-1:0];
      quo_q <= q;
      ovf_q <= ovf_i;
      pos_q <= pos_i;
    end
  end

  assign out_valid_o = valid_q;
  assign n_o         = n_q;
  assign rem_o       = rem_q;
  assign quo_o       = quo_q;
  assign ovf_o       = ovf_q;
  assign pos_o       = pos_q;

`include "particle_age_color_ramp_macros.svh"

  // Partial remainder stays below the divisor on the in-range path
  `PACR_ASSERT_NOW(a_rem_below_ha, clk_i, rst_ni, valid_q && !ovf_q, rem_q < ha_i)

endmodule

/* hw/rtl/pacr_blend.sv */
// Segment select, fraction multiply and rounding: three register stages.
// Depends on pacr_pkg for position and color types.
module pacr_blend #(
  parameter int NUM_COLOR_STOPS = pacr_pkg::NUM_COLOR_STOPS_DEF,
  parameter int NW              = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pacr_pkg::STOP_W-1:0] stops_i [NUM_COLOR_STOPS],
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [NW-1:0]               quo_i,
  input  logic                        ovf_i,
  input  pacr_pkg::pos_t              pos_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pacr_pkg::pos_t              pos_o,
  output pacr_pkg::rgb_t              rgb_o
);

  localparam int SLOTS = NUM_COLOR_STOPS - 1;
  localparam int SEG_W = NW - pacr_pkg::FRAC_W;
  localparam int CW    = pacr_pkg::CH_W;
  localparam int TW    = pacr_pkg::FRAC_W + 1;
  localparam int PW    = CW + 1 + TW + 1;
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SLOTS - 1);
  localparam logic [TW-1:0]    T_ONE    = TW'(1) << pacr_pkg::FRAC_W;

  logic [2*pacr_pkg::STOP_W-1:0] pair [SLOTS];
  logic [2*pacr_pkg::STOP_W-1:0] pair_sel;
  logic [SEG_W-1:0]              seg;
  logic [TW-1:0]                 t;
  logic [CW-1:0]                 a_ch [3];
  logic signed [CW:0]            d_ch [3];

  logic                  v1_q, v2_q, v3_q;
  logic                  rdy1, rdy2, rdy3;
  logic [TW-1:0]         t1_q;
  logic [CW-1:0]         a1_q [3];
  logic signed [CW:0]    d1_q [3];
  pacr_pkg::pos_t        pos1_q, pos2_q, pos3_q;
  logic [CW-1:0]         a2_q [3];
  logic signed [PW-1:0]  prod2_q [3];
  logic signed [PW-1:0]  rnd [3];
  pacr_pkg::rgb_t        rgb3_q;
  pacr_pkg::rgb_t        rgb_d;

  // Neighbor stop pairs, one entry per segment
  for (genvar k = 0; k < SLOTS; k++) begin : g_pair
    assign pair[k] = {stops_i[k+1], stops_i[k]};
  end

  // Clamp segment and fraction, then pick the stop pair
  always_comb begin
    seg      = ovf_i ? SEG_LAST : quo_i[NW-1:pacr_pkg::FRAC_W];
    t        = ovf_i ? T_ONE : {1'b0, quo_i[pacr_pkg::FRAC_W-1:0]};
    pair_sel = pair[seg];
    for (int c = 0; c < 3; c++) begin
      a_ch[c] = pair_sel[pacr_pkg::STOP_W-1-c*CW -: CW];
      d_ch[c] = $signed({1'b0, pair_sel[2*pacr_pkg::STOP_W-1-c*CW -: CW]})
              - $signed({1'b0, a_ch[c]});
    end
  end

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage 1: base color, channel difference and fraction
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      t1_q   <= t;
      a1_q   <= a_ch;
      d1_q   <= d_ch;
      pos1_q <= pos_i;
    end
  end

  // Stage 2: difference times fraction
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      for (int c = 0; c < 3; c++) begin
        prod2_q[c] <= PW'(d1_q[c] * $signed({1'b0, t1_q}));
      end
      a2_q   <= a1_q;
      pos2_q <= pos1_q;
    end
  end

  // Round to nearest and add back the base color
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = prod2_q[c] + PW'(32768);
    end
    rgb_d.red   = a2_q[0] + rnd[0][pacr_pkg::FRAC_W +: CW];
    rgb_d.green = a2_q[1] + rnd[1][pacr_pkg::FRAC_W +: CW];
    rgb_d.blue  = a2_q[2] + rnd[2][pacr_pkg::FRAC_W +: CW];
  end

  // Stage 3: output register
  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      rgb3_q <= rgb_d;
      pos3_q <= pos2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign pos_o       = pos3_q;
  assign rgb_o       = rgb3_q;

`include "particle_age_color_ramp_macros.svh"

  // A full-scale fraction carries no fractional bits
  `PACR_ASSERT_NOW(a_t_one_clean, clk_i, rst_ni, v1_q && t1_q[TW-1], t1_q[TW-2:0] == '0)

endmodule

/* hw/rtl/particle_age_color_ramp.sv */
// Particle age color ramp: throughput one particle per cycle while m_axis_tready is high;
// the divider is cut into stages of up to 4 quotient bits each.
// Hidden particles are dropped at the input and take one transfer slot only.
// Reset is asynchronous, active low: clears all valid bits, loads default registers.
// Depends on pacr_pkg, pacr_cfg_regs, pacr_div_stage and pacr_blend.
module particle_age_color_ramp #(
  parameter int NUM_COLOR_STOPS = pacr_pkg::NUM_COLOR_STOPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // x[31:0], y[63:32], z[95:64], particle_age[111:96]
  input  logic [111:0]                    s_axis_tdata,
  // is_hidden[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // x[31:0], y[63:32], z[95:64], red[111:96], green[127:112], blue[143:128]
  output logic [143:0]                    m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pacr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pacr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pacr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int SLOTS      = NUM_COLOR_STOPS - 1;
  localparam int SEG_W      = $clog2(NUM_COLOR_STOPS);
  localparam int NW         = pacr_pkg::FRAC_W + SEG_W;
  localparam int STEPS      = pacr_pkg::DIV_STEPS;
  localparam int DIV_STAGES = (NW + STEPS - 1) / STEPS;
  localparam int HA_W       = pacr_pkg::HA_W;

  logic [HA_W-1:0]             high_age;
  logic [HA_W-1:0]             ha_eff;
  logic [pacr_pkg::STOP_W-1:0] stops [NUM_COLOR_STOPS];
  pacr_pkg::pos_t              pos_in;
  logic [NW-1:0]               n_d;
  logic [NW-1:0]               span;

  logic                        s0_valid_q;
  logic                        s0_ready;
  logic [NW-1:0]               s0_n_q;
  logic                        s0_ovf_q;
  pacr_pkg::pos_t              s0_pos_q;

  logic                        dv_valid [DIV_STAGES+1];
  logic                        dv_ready [DIV_STAGES+1];
  logic [NW-1:0]               dv_n     [DIV_STAGES+1];
  logic [HA_W-1:0]             dv_rem   [DIV_STAGES+1];
  logic [NW-1:0]               dv_quo   [DIV_STAGES+1];
  logic                        dv_ovf   [DIV_STAGES+1];
  pacr_pkg::pos_t              dv_pos   [DIV_STAGES+1];

  pacr_pkg::pos_t              pos_out;
  pacr_pkg::rgb_t              rgb_out;

  pacr_cfg_regs #(
    .NUM_COLOR_STOPS (NUM_COLOR_STOPS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .high_age_o (high_age),
    .stops_o    (stops)
  );

  // Zero high age behaves as one
  assign ha_eff = (high_age == '0) ? HA_W'(1) : high_age;

  assign pos_in.x = s_axis_tdata[31:0];
  assign pos_in.y = s_axis_tdata[63:32];
  assign pos_in.z = s_axis_tdata[95:64];

  // Scale the age by the segment count; beyond the last stop saturates
  assign n_d  = NW'(s_axis_tdata[111:96]) * NW'(SLOTS);
  assign span = NW'(ha_eff) * NW'(SLOTS);

  assign s0_ready      = !s0_valid_q || dv_ready[0];
  assign s_axis_tready = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= s_axis_tvalid && !s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && s_axis_tvalid) begin
      s0_n_q   <= n_d;
      s0_ovf_q <= (n_d >= span);
      s0_pos_q <= pos_in;
    end
  end

  // Seed the divider: top dividend bits are the first partial remainder
  assign dv_valid[0] = s0_valid_q;
  assign dv_n[0]     = s0_n_q;
  assign dv_rem[0]   = s0_n_q[NW-1 -: HA_W];
  assign dv_quo[0]   = '0;
  assign dv_ovf[0]   = s0_ovf_q;
  assign dv_pos[0]   = s0_pos_q;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int BASE_K  = NW - 1 - k * STEPS;
    localparam int STEPS_K = (NW - k * STEPS >= STEPS) ? STEPS : NW - k * STEPS;
    pacr_div_stage #(
      .NW    (NW),
      .BASE  (BASE_K),
      .STEPS (STEPS_K)
    ) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ha_i        (ha_eff),
      .in_valid_i  (dv_valid[k]),
      .in_ready_o  (dv_ready[k]),
      .n_i         (dv_n[k]),
      .rem_i       (dv_rem[k]),
      .quo_i       (dv_quo[k]),
      .ovf_i       (dv_ovf[k]),
      .pos_i       (dv_pos[k]),
      .out_valid_o (dv_valid[k+1]),
      .out_ready_i (dv_ready[k+1]),
      .n_o         (dv_n[k+1]),
      .rem_o       (dv_rem[k+1]),
      .quo_o       (dv_quo[k+1]),
      .ovf_o       (dv_ovf[k+1]),
      .pos_o       (dv_pos[k+1])
    );
  end

  pacr_blend #(
    .NUM_COLOR_STOPS (NUM_COLOR_STOPS),
    .NW              (NW)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stops_i     (stops),
    .in_valid_i  (dv_valid[DIV_STAGES]),
    .in_ready_o  (dv_ready[DIV_STAGES]),
    .quo_i       (dv_quo[DIV_STAGES]),
    .ovf_i       (dv_ovf[DIV_STAGES]),
    .pos_i       (dv_pos[DIV_STAGES]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pos_o       (pos_out),
    .rgb_o       (rgb_out)
  );

  assign m_axis_tdata = {rgb_out.blue, rgb_out.green, rgb_out.red,
                         pos_out.z, pos_out.y, pos_out.x};

`include "particle_age_color_ramp_macros.svh"

  // A hidden particle never reaches the first stage
  `PACR_ASSERT_NEXT(a_hidden_dropped, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s0_valid_q)

endmodule
